// ===== rtl/core/ptms_pkg.sv =====
// shared constants, register codes and stage types for the temporal mean/std core
`timescale 1ns / 1ps

package ptms_pkg;

  // sizing
  localparam int MaxPixels  = 16384;
  localparam int MaxFrames  = 4096;
  localparam int SampleBits = 16;

  // field and datapath widths
  localparam int PixW    = 16;
  localparam int PosW    = 14;
  localparam int CntW    = 15;
  localparam int FrameW  = 13;
  localparam int TickW   = 32;
  localparam int SumW    = 28;
  localparam int SqW     = 44;
  localparam int Q8W     = 24;
  localparam int FracBits = 8;
  localparam int ProdW   = 57;
  localparam int MulW    = 24;
  localparam int VarQW   = 48;
  localparam int VarFrac = 16;
  localparam int MeanQW  = 24;
  localparam int AddrW   = 4;
  localparam int DataW   = 32;
  localparam int OutDataW = 80;

  // register reset values
  localparam logic [FrameW-1:0] FrameLimitRst = 13'd16;
  localparam logic [TickW-1:0]  TimeoutRst    = 32'hFFFF_FFFF;
  localparam logic [CntW-1:0]   PixelCountRst = 15'd16384;

  // register index codes (byte address bits [3:2])
  typedef enum logic [1:0] {
    RegFrameLimit = 2'd0,
    RegTimeout    = 2'd1,
    RegPixelCount = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [FrameW-1:0] frame_limit;
    logic [TickW-1:0]  timeout_ticks;
    logic [CntW-1:0]   pixel_count;
  } cfg_t;

  // accumulated pixel leaving the sum stage
  typedef struct packed {
    logic              valid;
    logic [PosW-1:0]   pos;
    logic [FrameW-1:0] n;
    logic              last;
    logic [SumW-1:0]   sx;
    logic [SqW-1:0]    sxx;
  } acc_t;

  // sideband carried through the variance divider
  typedef struct packed {
    logic [PosW-1:0]   pos;
    logic [FrameW-1:0] n;
    logic              last;
    logic [SumW-1:0]   sx;
    logic              msat;
    logic              ssat;
    logic              sv;
  } var_side_t;

  // sideband carried through the mean divider
  typedef struct packed {
    logic [PosW-1:0]   pos;
    logic [FrameW-1:0] n;
    logic              last;
    logic              msat;
  } mean_side_t;

  // sideband carried through the square root
  typedef struct packed {
    logic ssat;
    logic sv;
  } root_side_t;

  // one beat held in the output queue
  typedef struct packed {
    logic                last;
    logic                user;
    logic [OutDataW-1:0] data;
  } obeat_t;

endpackage

// ===== rtl/core/ptms_accum.sv =====
// frame sequencing, per-pixel sum stores and accumulate stage
`timescale 1ns / 1ps

module ptms_accum (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      pix_acc_i,
  input  logic                      tick_acc_i,
  input  logic [ptms_pkg::PixW-1:0] pixel_value_i,
  input  ptms_pkg::cfg_t            cfg_i,
  output ptms_pkg::acc_t            acc_o
);
  import ptms_pkg::*;

  // sequencing state
  logic [PosW-1:0]   pos_q, pos_d;
  logic [FrameW-1:0] frame_q, frame_d;
  logic [TickW-1:0]  elapsed_q, elapsed_d;
  logic              bstart_q, bstart_d;
  logic              closing_q, closing_d;

  logic [CntW-1:0]   cnt_eff;
  logic [FrameW:0]   frame_inc;
  logic [FrameW-1:0] n_new, n_cur, n_eff;
  logic              first, close_new, close_cur, last;
  logic [PixW-1:0]   x;

  // frame start decision and position bookkeeping
  always_comb begin
    if (cfg_i.pixel_count == '0) begin
      cnt_eff = CntW'(1);
    end else if (cfg_i.pixel_count > CntW'(MaxPixels)) begin
      cnt_eff = CntW'(MaxPixels);
    end else begin
      cnt_eff = cfg_i.pixel_count;
    end
    first     = (pos_q == '0);
    frame_inc = {1'b0, frame_q} + 1'b1;
    n_new     = (frame_inc > (FrameW + 1)'(MaxFrames)) ? FrameW'(MaxFrames)
                                                       : frame_inc[FrameW-1:0];
    close_new = (n_new >= cfg_i.frame_limit) || (elapsed_q > cfg_i.timeout_ticks) ||
                (n_new >= FrameW'(MaxFrames));
    n_cur     = first ? n_new : frame_q;
    n_eff     = (n_cur == '0) ? FrameW'(1) : n_cur;
    close_cur = first ? close_new : closing_q;
    last      = ({1'b0, pos_q} + 1'b1) >= cnt_eff;
    x         = PixW'(pixel_value_i[SampleBits-1:0]);

    pos_d     = pos_q;
    frame_d   = frame_q;
    elapsed_d = elapsed_q;
    bstart_d  = bstart_q;
    closing_d = closing_q;
    if (tick_acc_i) begin
      elapsed_d = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
    end else if (pix_acc_i) begin
      pos_d     = last ? '0 : pos_q + 1'b1;
      frame_d   = (close_cur && last) ? '0 : n_cur;
      elapsed_d = (close_cur && last) ? '0 : elapsed_q;
      closing_d = close_cur && !last;
      bstart_d  = last ? close_cur : bstart_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      frame_q   <= '0;
      elapsed_q <= '0;
      bstart_q  <= 1'b1;
      closing_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      frame_q   <= frame_d;
      elapsed_q <= elapsed_d;
      bstart_q  <= bstart_d;
      closing_q <= closing_d;
    end
  end

  // read stage: payload of the pixel whose sums are being fetched
  logic                s1_v_q;
  logic [PosW-1:0]     s1_pos_q;
  logic [PixW-1:0]     s1_x_q;
  logic [2*PixW-1:0]   s1_x2_q;
  logic [FrameW-1:0]   s1_n_q;
  logic                s1_close_q, s1_bstart_q, s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= pix_acc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc_i) begin
      s1_pos_q    <= pos_q;
      s1_x_q      <= x;
      s1_x2_q     <= x * x;
      s1_n_q      <= n_eff;
      s1_close_q  <= close_cur;
      s1_bstart_q <= bstart_q;
      s1_last_q   <= last;
    end
  end

  // sum stores, registered read
  logic [SumW-1:0] sum_mem [MaxPixels];
  logic [SqW-1:0]  sq_mem  [MaxPixels];
  logic [SumW-1:0] sum_rd_q;
  logic [SqW-1:0]  sq_rd_q;
  logic            wr_en;
  logic [SumW-1:0] sx_new;
  logic [SqW-1:0]  sxx_new;

  always_ff @(posedge clk_i) begin
    if (pix_acc_i) begin
      sum_rd_q <= sum_mem[pos_q];
      sq_rd_q  <= sq_mem[pos_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sum_mem[s1_pos_q] <= sx_new;
      sq_mem[s1_pos_q]  <= sxx_new;
    end
  end

  // last write, forwarded when the same pixel is read back right away
  logic            fwd_v_q;
  logic [PosW-1:0] fwd_pos_q;
  logic [SumW-1:0] fwd_sx_q;
  logic [SqW-1:0]  fwd_sxx_q;
  logic            fwd_hit;
  logic [SumW-1:0] old_sx;
  logic [SqW-1:0]  old_sxx;

  always_comb begin
    wr_en   = en_i && s1_v_q;
    fwd_hit = fwd_v_q && (fwd_pos_q == s1_pos_q);
    old_sx  = fwd_hit ? fwd_sx_q : sum_rd_q;
    old_sxx = fwd_hit ? fwd_sxx_q : sq_rd_q;
    sx_new  = s1_bstart_q ? SumW'(s1_x_q) : old_sx + SumW'(s1_x_q);
    sxx_new = s1_bstart_q ? SqW'(s1_x2_q) : old_sxx + SqW'(s1_x2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
    end else if (wr_en) begin
      fwd_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_pos_q <= s1_pos_q;
      fwd_sx_q  <= sx_new;
      fwd_sxx_q <= sxx_new;
    end
  end

  // accumulate stage output, only pixels of a closing frame go on
  acc_t acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q.valid <= 1'b0;
    end else if (en_i) begin
      acc_q.valid <= s1_v_q && s1_close_q;
      acc_q.pos   <= s1_pos_q;
      acc_q.n     <= s1_n_q;
      acc_q.last  <= s1_last_q;
      acc_q.sx    <= sx_new;
      acc_q.sxx   <= sxx_new;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/core/ptms_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module ptms_div #(
  parameter int QW = 24,
  parameter int DW = 13,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] num_i,
  input  logic [DW-1:0] div_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  logic          valid_q [QW];
  logic [DW-1:0] rem_q   [QW];
  logic [QW-1:0] num_q   [QW];
  logic [DW-1:0] div_q   [QW];
  logic [QW-1:0] quot_q  [QW];
  logic [SW-1:0] side_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] r_in, d_in;
    logic [QW-1:0] n_in, q_in;
    logic [SW-1:0] s_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = rem_i;
      assign n_in = num_i;
      assign d_in = div_i;
      assign q_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = valid_q[k-1];
      assign r_in = rem_q[k-1];
      assign n_in = num_q[k-1];
      assign d_in = div_q[k-1];
      assign q_in = quot_q[k-1];
      assign s_in = side_q[k-1];
    end

    // shift in the next dividend bit and try a subtract
    assign trial = {r_in, n_in[QW-1]};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? DW'(trial - {1'b0, d_in}) : trial[DW-1:0];
        num_q[k]  <= {n_in[QW-2:0], 1'b0};
        div_q[k]  <= d_in;
        quot_q[k] <= {q_in[QW-2:0], ge};
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = valid_q[QW-1];
  assign quot_o  = quot_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// ===== rtl/core/ptms_isqrt.sv =====
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps

module ptms_isqrt #(
  parameter int RW = 24,
  parameter int SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*RW-1:0] val_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  logic            valid_q [RW];
  logic [RW+1:0]   rem_q   [RW];
  logic [RW-1:0]   root_q  [RW];
  logic [2*RW-1:0] val_q   [RW];
  logic [SW-1:0]   side_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            v_in;
    logic [RW+1:0]   r_in, rem2, trial;
    logic [RW-1:0]   q_in;
    logic [2*RW-1:0] x_in;
    logic [SW-1:0]   s_in;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = '0;
      assign q_in = '0;
      assign x_in = val_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = valid_q[k-1];
      assign r_in = rem_q[k-1];
      assign q_in = root_q[k-1];
      assign x_in = val_q[k-1];
      assign s_in = side_q[k-1];
    end

    // bring down two radicand bits, trial subtract 4*root+1
    assign rem2  = {r_in[RW-1:0], x_in[2*RW-1 -: 2]};
    assign trial = {q_in, 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? rem2 - trial : rem2;
        root_q[k] <= {q_in[RW-2:0], ge};
        val_q[k]  <= {x_in[2*RW-3:0], 2'b00};
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = valid_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

// ===== rtl/core/pixel_temporal_mean_std_core.sv =====
// Per-pixel temporal mean and sample standard deviation over batches of frames.
// Pixel samples (tuser 0) and timer ticks (tuser 1) enter on the slave stream at
// one beat per clock; pixels of a closing frame leave on the master stream with
// mean and std in unsigned Q16.8. The pipeline is fully stalled as one unit by
// a two-entry output queue, so a beat enters on every cycle that the consumer
// keeps up. After a pixel is accepted it passes through registers for sequencing
// and the sum-store read/modify/write, registers for products,
// difference and saturation checks, a 48-stage variance divider, then a 24-stage
// square root running beside a 24-stage mean divider, and the output register.
// The sum stores hold 16384 entries each and are read and written once per
// cycle; a pixel revisited on the next cycle is served from a forwarding register.
`timescale 1ns / 1ps

module pixel_temporal_mean_std_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // slave stream, tdata: pixel_value[15:0]; tuser: kind[0]
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [15:0]               s_axis_tdata,
  input  logic [0:0]                s_axis_tuser,
  // master stream, tdata: pixel_index[13:0], mean_q8[37:14], std_q8[61:38],
  // frames_used[74:62], zero[79:75]; tuser: std_valid[0]
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [79:0]               m_axis_tdata,
  output logic [0:0]                m_axis_tuser,
  output logic                      m_axis_tlast,
  // register port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ptms_pkg::AddrW-1:0] paddr,
  input  logic [ptms_pkg::DataW-1:0] pwdata,
  output logic [ptms_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import ptms_pkg::*;

  localparam int MeanSplit = MeanQW - FracBits;

  // configuration registers
  cfg_t cfg_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_limit   <= FrameLimitRst;
      cfg_q.timeout_ticks <= TimeoutRst;
      cfg_q.pixel_count   <= PixelCountRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegFrameLimit: cfg_q.frame_limit   <= pwdata[FrameW-1:0];
        RegTimeout:    cfg_q.timeout_ticks <= pwdata[TickW-1:0];
        RegPixelCount: cfg_q.pixel_count   <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegFrameLimit: prdata = DataW'(cfg_q.frame_limit);
      RegTimeout:    prdata = DataW'(cfg_q.timeout_ticks);
      RegPixelCount: prdata = DataW'(cfg_q.pixel_count);
      default:       prdata = '0;
    endcase
  end

  // global advance, held while the output queue is full
  logic [1:0] cnt_q;
  logic       en, pix_acc, tick_acc;

  assign en            = (cnt_q != 2'd2);
  assign s_axis_tready = en;
  assign pix_acc       = s_axis_tvalid && en && !s_axis_tuser[0];
  assign tick_acc      = s_axis_tvalid && en && s_axis_tuser[0];

  acc_t acc;

  ptms_accum u_accum (
    .clk_i,
    .rst_ni,
    .en_i          (en),
    .pix_acc_i     (pix_acc),
    .tick_acc_i    (tick_acc),
    .pixel_value_i (s_axis_tdata),
    .cfg_i         (cfg_q),
    .acc_o         (acc)
  );

  // products: n*sxx, sx^2, n*(n-1)
  logic              s3_v_q;
  logic [PosW-1:0]   s3_pos_q;
  logic [FrameW-1:0] s3_n_q;
  logic              s3_last_q, s3_msat_q, s3_sv_q;
  logic [SumW-1:0]   s3_sx_q;
  logic [ProdW-1:0]  s3_a_q, s3_b_q;
  logic [MulW-1:0]   s3_m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= acc.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_pos_q  <= acc.pos;
      s3_n_q    <= acc.n;
      s3_last_q <= acc.last;
      s3_sx_q   <= acc.sx;
      s3_a_q    <= ProdW'(acc.n) * ProdW'(acc.sxx);
      s3_b_q    <= ProdW'(acc.sx) * ProdW'(acc.sx);
      s3_m_q    <= MulW'(acc.n) * MulW'(acc.n - 1'b1);
      s3_msat_q <= FrameW'(acc.sx >> MeanSplit) >= acc.n;
      s3_sv_q   <= acc.n >= FrameW'(2);
    end
  end

  // difference, clamped at zero
  logic              s4_v_q;
  logic [PosW-1:0]   s4_pos_q;
  logic [FrameW-1:0] s4_n_q;
  logic              s4_last_q, s4_msat_q, s4_sv_q;
  logic [SumW-1:0]   s4_sx_q;
  logic [ProdW-1:0]  s4_d_q;
  logic [MulW-1:0]   s4_m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_pos_q  <= s3_pos_q;
      s4_n_q    <= s3_n_q;
      s4_last_q <= s3_last_q;
      s4_sx_q   <= s3_sx_q;
      s4_d_q    <= (s3_a_q > s3_b_q) ? s3_a_q - s3_b_q : '0;
      s4_m_q    <= s3_m_q;
      s4_msat_q <= s3_msat_q;
      s4_sv_q   <= s3_sv_q;
    end
  end

  // std saturates when d*2^16/m would reach 2^48
  logic                     s5_v_q;
  var_side_t                s5_side_q;
  logic [MulW-1:0]          s5_rem_q, s5_m_q;
  logic [VarQW-VarFrac-1:0] s5_dlo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (en) begin
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_side_q.pos  <= s4_pos_q;
      s5_side_q.n    <= s4_n_q;
      s5_side_q.last <= s4_last_q;
      s5_side_q.sx   <= s4_sx_q;
      s5_side_q.msat <= s4_msat_q;
      s5_side_q.sv   <= s4_sv_q;
      s5_side_q.ssat <= s4_d_q[ProdW-1:VarQW-VarFrac] >= {1'b0, s4_m_q};
      s5_rem_q       <= s4_d_q[ProdW-2:VarQW-VarFrac];
      s5_dlo_q       <= s4_d_q[VarQW-VarFrac-1:0];
      s5_m_q         <= s4_m_q;
    end
  end

  // variance quotient
  logic             var_v;
  logic [VarQW-1:0] var_q;
  var_side_t        var_side;

  ptms_div #(
    .QW ( VarQW ),
    .DW ( MulW ),
    .SW ( $bits(var_side_t) )
  ) u_var_div (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .valid_i (s5_v_q),
    .rem_i   (s5_rem_q),
    .num_i   ({s5_dlo_q, VarFrac'(0)}),
    .div_i   (s5_m_q),
    .side_i  (s5_side_q),
    .valid_o (var_v),
    .quot_o  (var_q),
    .side_o  (var_side)
  );

  // mean divider beside the square root
  logic              mean_v, root_v;
  logic [MeanQW-1:0] mean_q;
  logic [Q8W-1:0]    root;
  mean_side_t        mean_side_in, mean_side;
  root_side_t        root_side_in, root_side;

  always_comb begin
    mean_side_in.pos  = var_side.pos;
    mean_side_in.n    = var_side.n;
    mean_side_in.last = var_side.last;
    mean_side_in.msat = var_side.msat;
    root_side_in.ssat = var_side.ssat;
    root_side_in.sv   = var_side.sv;
  end

  ptms_div #(
    .QW ( MeanQW ),
    .DW ( FrameW ),
    .SW ( $bits(mean_side_t) )
  ) u_mean_div (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .valid_i (var_v),
    .rem_i   (FrameW'(var_side.sx >> MeanSplit)),
    .num_i   (MeanQW'({var_side.sx, FracBits'(0)})),
    .div_i   (var_side.n),
    .side_i  (mean_side_in),
    .valid_o (mean_v),
    .quot_o  (mean_q),
    .side_o  (mean_side)
  );

  ptms_isqrt #(
    .RW ( Q8W ),
    .SW ( $bits(root_side_t) )
  ) u_isqrt (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .valid_i (var_v),
    .val_i   (var_q),
    .side_i  (root_side_in),
    .valid_o (root_v),
    .root_o  (root),
    .side_o  (root_side)
  );

  // result beat
  obeat_t         beat;
  logic [Q8W-1:0] mean_out, std_out;

  always_comb begin
    mean_out  = mean_side.msat ? '1 : mean_q;
    std_out   = root_side.sv ? (root_side.ssat ? '1 : root) : '0;
    beat.last = mean_side.last;
    beat.user = root_side.sv;
    beat.data = OutDataW'({mean_side.n, std_out, mean_out, mean_side.pos});
  end

  // two-entry output queue
  obeat_t fifo_q [2];
  logic   wr_ptr_q, rd_ptr_q;
  logic   push, pop;

  assign push = en && mean_v;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= beat;
    end
  end

  assign m_axis_tvalid   = (cnt_q != 2'd0);
  assign m_axis_tdata    = fifo_q[rd_ptr_q].data;
  assign m_axis_tuser[0] = fifo_q[rd_ptr_q].user;
  assign m_axis_tlast    = fifo_q[rd_ptr_q].last;

`ifndef SYNTHESIS
  // the square root and the mean divider run in lock step
  a_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mean_v == root_v)
    else $error("mean and root pipelines out of step");

  // queue occupancy stays within its two entries
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output queue overflow");

  // a full queue freezes the pipeline so no result is pushed
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) && !pop |=> cnt_q == 2'd2 || $past(pop))
    else $error("result pushed into a full queue");
`endif

endmodule
